// ===== hdl/spr_pkg.sv =====
// Package for the stream pattern replace block: shared widths, register
// indexes, payload structs, controller states and command/status structs.
// Used by every module of the block; depends on nothing.
package spr_pkg;

   localparam int BYTE_W    = 8;
   localparam int LEN_W     = 4;
   localparam int CFG_W     = 64;
   localparam int COUNT_W   = 16;
   localparam int CSR_IDX_W = 2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NEEDLE_BYTES = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NEEDLE_LEN   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REPL_BYTES   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REPL_LEN     = 2'd3;

   localparam logic [LEN_W-1:0] NEEDLE_LEN_RESET = 4'd1;
   localparam logic [LEN_W-1:0] REPL_LEN_RESET   = 4'd0;

   typedef struct packed {
      logic [BYTE_W-1:0] in_byte;
      logic              is_last;
   } spr_req_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  out_byte;
      logic               byte_valid;
      logic               end_of_string;
      logic [COUNT_W-1:0] match_count;
      logic               needle_error;
   } spr_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_REPL,
      ST_FLUSH,
      ST_END
   } spr_state_type;

   typedef enum logic [1:0] {
      EMIT_NONE,
      EMIT_HEAD,
      EMIT_REPL,
      EMIT_END
   } spr_emit_type;

   typedef struct packed {
      logic         accept;
      spr_emit_type emit;
      logic         shift;
      logic         matched;
      logic         repl_adv;
      logic         end_clear;
   } spr_cmd_type;

   typedef struct packed {
      logic nlen_zero;
      logic fill_ge_nlen;
      logic win_match;
      logic fill_zero;
      logic repl_empty;
      logic repl_last;
      logic last;
      logic slot_free;
   } spr_status_type;

endpackage

// ===== hdl/spr_ctrl.sv =====
// Controller state machine for the stream pattern replace block.
// Sequences accept, compare, replacement, flush and end marker steps.
// Depends on spr_pkg.
module spr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  spr_pkg::spr_status_type status,
   output spr_pkg::spr_cmd_type    cmd
);

   spr_pkg::spr_state_type state_ff;
   spr_pkg::spr_state_type state_in;
   spr_pkg::spr_state_type post_state;

   assign post_state = status.last ? spr_pkg::ST_FLUSH : spr_pkg::ST_IDLE;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= spr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         spr_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = spr_pkg::ST_CHECK;
            end
         end
         spr_pkg::ST_CHECK: begin
            priority if (status.nlen_zero) begin
               if (status.slot_free) begin
                  state_in = post_state;
               end
            end else if (status.fill_ge_nlen) begin
               priority if (status.win_match) begin
                  state_in = status.repl_empty ? post_state : spr_pkg::ST_REPL;
               end else if (status.slot_free) begin
                  state_in = post_state;
               end else begin
                  state_in = state_ff;
               end
            end else begin
               state_in = post_state;
            end
         end
         spr_pkg::ST_REPL: begin
            if (status.slot_free && status.repl_last) begin
               state_in = post_state;
            end
         end
         spr_pkg::ST_FLUSH: begin
            if (status.fill_zero) begin
               state_in = spr_pkg::ST_END;
            end
         end
         spr_pkg::ST_END: begin
            if (status.slot_free) begin
               state_in = spr_pkg::ST_IDLE;
            end
         end
         default: state_in = spr_pkg::ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      cmd.emit  = spr_pkg::EMIT_NONE;
      unique case (state_ff)
         spr_pkg::ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         spr_pkg::ST_CHECK: begin
            priority if (status.nlen_zero) begin
               // pass the byte straight through
               if (status.slot_free) begin
                  cmd.emit = spr_pkg::EMIT_HEAD;
               end
            end else if (status.fill_ge_nlen) begin
               priority if (status.win_match) begin
                  cmd.matched = 1'b1;
               end else if (status.slot_free) begin
                  cmd.emit  = spr_pkg::EMIT_HEAD;
                  cmd.shift = 1'b1;
               end else begin
                  cmd.shift = 1'b0;
               end
            end else begin
               cmd.emit = spr_pkg::EMIT_NONE;
            end
         end
         spr_pkg::ST_REPL: begin
            if (status.slot_free) begin
               cmd.emit     = spr_pkg::EMIT_REPL;
               cmd.repl_adv = 1'b1;
            end
         end
         spr_pkg::ST_FLUSH: begin
            if (!status.fill_zero && status.slot_free) begin
               cmd.emit  = spr_pkg::EMIT_HEAD;
               cmd.shift = 1'b1;
            end
         end
         spr_pkg::ST_END: begin
            if (status.slot_free) begin
               cmd.emit      = spr_pkg::EMIT_END;
               cmd.end_clear = 1'b1;
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// ===== hdl/spr_datapath.sv =====
// Datapath for the stream pattern replace block: configuration registers,
// per-string latched configuration, byte window, match counter, output register.
// Depends on spr_pkg; driven by spr_ctrl through command and status structs.
module spr_datapath #(
   parameter int NEEDLE_MAX      = 8,
   parameter int REPLACEMENT_MAX = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  spr_pkg::spr_req_type                  req_data,
   input  logic                                  csr_write,
   input  logic [spr_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [spr_pkg::CFG_W-1:0]             csr_wdata,
   input  spr_pkg::spr_cmd_type                  cmd,
   output spr_pkg::spr_status_type               status,
   input  logic                                  rsp_ready,
   output logic                                  rsp_valid,
   output spr_pkg::spr_rsp_type                  rsp_data
);

   localparam int BYTE_W     = spr_pkg::BYTE_W;
   localparam int LEN_W      = spr_pkg::LEN_W;
   localparam int COUNT_W    = spr_pkg::COUNT_W;
   localparam int FILL_W     = $clog2(NEEDLE_MAX + 1);
   localparam int NIDX_W     = (NEEDLE_MAX > 1) ? $clog2(NEEDLE_MAX) : 1;
   localparam int REPL_DEPTH = (REPLACEMENT_MAX > 0) ? REPLACEMENT_MAX : 1;
   localparam int RIDX_W     = (REPL_DEPTH > 1) ? $clog2(REPL_DEPTH) : 1;
   localparam logic [LEN_W-1:0] NMAX_LEN = LEN_W'(NEEDLE_MAX);
   localparam logic [LEN_W-1:0] RMAX_LEN = LEN_W'(REPLACEMENT_MAX);

   // Configuration registers
   logic [spr_pkg::CFG_W-1:0] needle_bytes_ff;
   logic [LEN_W-1:0]          needle_len_ff;
   logic [spr_pkg::CFG_W-1:0] repl_bytes_ff;
   logic [LEN_W-1:0]          repl_len_ff;

   // Per-string copy
   logic [BYTE_W-1:0] cur_needle_ff [NEEDLE_MAX];
   logic [FILL_W-1:0] cur_nlen_ff;
   logic [BYTE_W-1:0] cur_repl_ff [REPL_DEPTH];
   logic [LEN_W-1:0]  cur_rlen_ff;

   logic [BYTE_W-1:0]  window_ff [NEEDLE_MAX];
   logic [BYTE_W-1:0]  window_in [NEEDLE_MAX];
   logic [FILL_W-1:0]  fill_ff;
   logic [FILL_W-1:0]  fill_in;
   logic [RIDX_W-1:0]  ridx_ff;
   logic [COUNT_W-1:0] count_ff;
   logic               in_string_ff;
   logic               last_ff;

   logic                 rsp_valid_ff;
   spr_pkg::spr_rsp_type rsp_data_ff;
   spr_pkg::spr_rsp_type rsp_data_in;

   logic              new_string;
   logic [LEN_W-1:0]  nlen_sel;
   logic [LEN_W-1:0]  rlen_sel;
   logic [FILL_W-1:0] nlen_eff;
   logic [FILL_W-1:0] fill_eff;
   logic              win_match;

   always_ff @(posedge clock) begin
      if (reset) begin
         needle_bytes_ff <= '0;
         needle_len_ff   <= spr_pkg::NEEDLE_LEN_RESET;
         repl_bytes_ff   <= '0;
         repl_len_ff     <= spr_pkg::REPL_LEN_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            spr_pkg::CSR_NEEDLE_BYTES: needle_bytes_ff <= csr_wdata;
            spr_pkg::CSR_NEEDLE_LEN:   needle_len_ff   <= csr_wdata[LEN_W-1:0];
            spr_pkg::CSR_REPL_BYTES:   repl_bytes_ff   <= csr_wdata;
            spr_pkg::CSR_REPL_LEN:     repl_len_ff     <= csr_wdata[LEN_W-1:0];
            default: needle_len_ff <= needle_len_ff;
         endcase
      end
   end

   assign new_string = cmd.accept && !in_string_ff;
   assign nlen_sel   = (needle_len_ff > NMAX_LEN) ? NMAX_LEN : needle_len_ff;
   assign rlen_sel   = (repl_len_ff > RMAX_LEN) ? RMAX_LEN : repl_len_ff;
   assign nlen_eff   = new_string ? FILL_W'(nlen_sel) : cur_nlen_ff;
   assign fill_eff   = new_string ? '0 : fill_ff;

   // Latch configuration at the first byte of a string
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_nlen_ff <= FILL_W'(1);
         cur_rlen_ff <= '0;
      end else if (new_string) begin
         cur_nlen_ff <= FILL_W'(nlen_sel);
         cur_rlen_ff <= rlen_sel;
      end
   end

   always_ff @(posedge clock) begin
      if (new_string) begin
         for (int k = 0; k < NEEDLE_MAX; k++) begin
            cur_needle_ff[k] <= needle_bytes_ff[BYTE_W*k +: BYTE_W];
         end
         for (int k = 0; k < REPL_DEPTH; k++) begin
            cur_repl_ff[k] <= repl_bytes_ff[BYTE_W*k +: BYTE_W];
         end
      end
   end

   // Window: push at the fill point, or drop the oldest byte
   always_comb begin
      window_in = window_ff;
      if (cmd.accept) begin
         window_in[fill_eff[NIDX_W-1:0]] = req_data.in_byte;
      end else if (cmd.shift) begin
         for (int k = 0; k < NEEDLE_MAX - 1; k++) begin
            window_in[k] = window_ff[k+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      window_ff <= window_in;
   end

   always_comb begin
      fill_in = fill_ff;
      priority if (cmd.accept) begin
         fill_in = fill_eff + ((nlen_eff != '0) ? FILL_W'(1) : FILL_W'(0));
      end else if (cmd.matched) begin
         fill_in = '0;
      end else if (cmd.shift) begin
         fill_in = fill_ff - FILL_W'(1);
      end else begin
         fill_in = fill_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         count_ff     <= '0;
         in_string_ff <= 1'b0;
         last_ff      <= 1'b0;
         ridx_ff      <= '0;
      end else begin
         fill_ff <= fill_in;
         if (cmd.accept) begin
            in_string_ff <= !req_data.is_last;
            last_ff      <= req_data.is_last;
         end
         priority if (new_string || cmd.end_clear) begin
            count_ff <= '0;
         end else if (cmd.matched && count_ff != spr_pkg::COUNT_MAX) begin
            count_ff <= count_ff + COUNT_W'(1);
         end else begin
            count_ff <= count_ff;
         end
         priority if (cmd.matched) begin
            ridx_ff <= '0;
         end else if (cmd.repl_adv) begin
            ridx_ff <= ridx_ff + RIDX_W'(1);
         end else begin
            ridx_ff <= ridx_ff;
         end
      end
   end

   always_comb begin
      win_match = 1'b1;
      for (int k = 0; k < NEEDLE_MAX; k++) begin
         if (FILL_W'(k) < cur_nlen_ff && window_ff[k] != cur_needle_ff[k]) begin
            win_match = 1'b0;
         end
      end
   end

   assign status.nlen_zero    = (cur_nlen_ff == '0);
   assign status.fill_ge_nlen = (fill_ff >= cur_nlen_ff);
   assign status.win_match    = win_match;
   assign status.fill_zero    = (fill_ff == '0);
   assign status.repl_empty   = (cur_rlen_ff == '0);
   assign status.repl_last    = ((LEN_W'(ridx_ff) + LEN_W'(1)) == cur_rlen_ff);
   assign status.last         = last_ff;
   assign status.slot_free    = !rsp_valid_ff || rsp_ready;

   // Output register
   always_comb begin
      rsp_data_in = '0;
      unique case (cmd.emit)
         spr_pkg::EMIT_HEAD: begin
            rsp_data_in.out_byte   = window_ff[0];
            rsp_data_in.byte_valid = 1'b1;
         end
         spr_pkg::EMIT_REPL: begin
            rsp_data_in.out_byte   = cur_repl_ff[ridx_ff];
            rsp_data_in.byte_valid = 1'b1;
         end
         spr_pkg::EMIT_END: begin
            rsp_data_in.end_of_string = 1'b1;
            rsp_data_in.match_count   = count_ff;
            rsp_data_in.needle_error  = (cur_nlen_ff == '0);
         end
         spr_pkg::EMIT_NONE: begin
            rsp_data_in = '0;
         end
         default: rsp_data_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit != spr_pkg::EMIT_NONE) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit != spr_pkg::EMIT_NONE) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hdl/stream_pattern_replace_top.sv =====
// Stream pattern replace: replaces each leftmost, non-overlapping needle
// occurrence in a byte string with a replacement. Top level of the block.
// Depends on spr_pkg, spr_ctrl and spr_datapath.
//
// A byte that passes through is first accepted into the window in ST_IDLE; in
// ST_CHECK the window is compared and, once full, its oldest byte is emitted.
// A byte that completes a match is followed by the replacement bytes, emitted in
// order from ST_REPL. At the end of the string ST_FLUSH emits each byte left in
// the window, and ST_END emits the end marker once the window is empty. The
// controller steps at most one result per cycle into a single output register,
// and stalls while rsp_ready is low with a result waiting. The configuration
// is copied at the first byte of each string; writes take effect with the next
// string. The configuration port always accepts.
module stream_pattern_replace_top #(
   parameter int NEEDLE_MAX      = 8,
   parameter int REPLACEMENT_MAX = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  spr_pkg::spr_req_type          req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output spr_pkg::spr_rsp_type          rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [spr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [spr_pkg::CFG_W-1:0]     csr_wdata
);

   spr_pkg::spr_cmd_type    cmd;
   spr_pkg::spr_status_type status;

   assign csr_ready = 1'b1;

   spr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   spr_datapath #(
      .NEEDLE_MAX      (NEEDLE_MAX),
      .REPLACEMENT_MAX (REPLACEMENT_MAX)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hdl/spr_checker.sv =====
// Port-level checks for the stream pattern replace block, bound to the top level.
// Depends on spr_pkg and stream_pattern_replace_top.
module spr_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input spr_pkg::spr_rsp_type rsp_data
);

   // Hold a stalled result transaction
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or dropped");

   assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("result valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.byte_valid != rsp_data.end_of_string)
      else $error("result is neither a data byte nor an end marker");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.byte_valid |->
         rsp_data.match_count == '0 && !rsp_data.needle_error)
      else $error("data result carries marker fields");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.end_of_string && rsp_data.needle_error |->
         rsp_data.match_count == '0 && rsp_data.out_byte == '0)
      else $error("empty needle marker reports matches");

endmodule

bind stream_pattern_replace_top spr_checker u_spr_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
